>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("assertion failed");

// A condition that must be followed by another one in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Constants, sizes and fuzzy set tables for the fuzzy PD servo controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ERROR_SCALE = 3'd0;
	localparam logic [2:0] REG_RATE_SCALE  = 3'd1;
	localparam logic [2:0] REG_PERIOD      = 3'd2;
	localparam logic [2:0] REG_OUT_GAIN    = 3'd3;
	localparam logic [2:0] REG_OUT_MIN     = 3'd4;
	localparam logic [2:0] REG_OUT_MAX     = 3'd5;

	// Shared divider sizes: dividend, divisor and step counter widths.
	localparam int DIV_W   = 48;
	localparam int DSR_W   = 30;
	localparam int CNT_W   = 6;

	localparam int          NORM_ONE = 16384;
	localparam logic [16:0] MU_ONE   = 17'd65536;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	typedef logic signed [17:0] point_t;

	// Breakpoints of the five error sets (0..4) and three rate sets (5..7).
	function automatic point_t trap_point(input logic [2:0] k, input logic [1:0] p);
		point_t r;
		r = '0;
		case ({k, p})
			5'd0:  r = -18'sd49152;
			5'd1:  r = -18'sd32768;
			5'd2:  r = -18'sd10813;
			5'd3:  r = -18'sd9667;
			5'd4:  r = -18'sd10813;
			5'd5:  r = -18'sd9667;
			5'd6:  r = -18'sd4096;
			5'd7:  r = -18'sd2949;
			5'd8:  r = -18'sd4096;
			5'd9:  r = -18'sd2949;
			5'd10: r = 18'sd2949;
			5'd11: r = 18'sd4096;
			5'd12: r = 18'sd2949;
			5'd13: r = 18'sd4096;
			5'd14: r = 18'sd9667;
			5'd15: r = 18'sd10813;
			5'd16: r = 18'sd9667;
			5'd17: r = 18'sd10813;
			5'd18: r = 18'sd32768;
			5'd19: r = 18'sd49152;
			5'd20: r = -18'sd49152;
			5'd21: r = -18'sd32768;
			5'd22: r = -18'sd11469;
			5'd23: r = -18'sd8192;
			5'd24: r = -18'sd11469;
			5'd25: r = -18'sd8192;
			5'd26: r = 18'sd8192;
			5'd27: r = 18'sd11469;
			5'd28: r = 18'sd8192;
			5'd29: r = 18'sd11469;
			5'd30: r = 18'sd32768;
			5'd31: r = 18'sd49152;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Rule output singletons in Q0.16, from negative big to positive big.
	function automatic logic [15:0] singleton(input logic [2:0] idx);
		logic [15:0] r;
		r = '0;
		case (idx)
			3'd0: r = 16'd26214;
			3'd1: r = 16'd31457;
			3'd2: r = 16'd36700;
			3'd3: r = 16'd41943;
			3'd4: r = 16'd47841;
			3'd5: r = 16'd53084;
			3'd6: r = 16'd58982;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/fuzzy_pd_servo_controller_top.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_servo_controller_top
// Sugeno fuzzy PD controller turning pixel error samples into servo angles.
// ----------------------------------------------------------------------------
// Each accepted error sample produces exactly one drive angle. The work runs on
// one shared multiplier and one shared 48-step restoring divider under a small
// sequencer, and the input is not ready until the sample is finished. A sample
// takes a division each for error normalisation, rate normalisation, up to four
// membership slopes and the final weighted average, plus classification of the
// eight sets, the fifteen rules and set-up. The result waits in an output
// register, so a new sample may be taken while it waits; the next result is
// held back only until that one is taken.
`default_nettype none

`include "assert_macros.svh"

module fuzzy_pd_servo_controller_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [10:0] error_px,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [16:0] drive_angle,
	output logic        clipped,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [19:0] cfg_data
);
	import fpc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIV_NE = 4'd1;
	localparam logic [3:0] ST_DIFFM  = 4'd2;
	localparam logic [3:0] ST_NR_GO  = 4'd3;
	localparam logic [3:0] ST_DIV_NR = 4'd4;
	localparam logic [3:0] ST_MU     = 4'd5;
	localparam logic [3:0] ST_MU_DIV = 4'd6;
	localparam logic [3:0] ST_RW     = 4'd7;
	localparam logic [3:0] ST_RN     = 4'd8;
	localparam logic [3:0] ST_U_GO   = 4'd9;
	localparam logic [3:0] ST_DIV_U  = 4'd10;
	localparam logic [3:0] ST_ANG    = 4'd11;

	// Configuration registers.
	logic [9:0]  error_scale_q, rate_scale_q, esc_eff, rsc_eff;
	logic [19:0] period_q, per_eff;
	logic [8:0]  out_gain_q, out_min_q, out_max_q;

	// Sequencer and datapath state.
	logic [3:0]         state_q;
	logic signed [10:0] prev_q;
	logic               sign_e_q, sign_d_q;
	logic [11:0]        mag_d_q;
	logic [30:0]        tmp_q;
	logic signed [15:0] ne_q, nr_q;
	logic [2:0]         k_q, ri_q;
	logic [1:0]         rj_q;
	logic [16:0]        mu_e_q [5];
	logic [16:0]        mu_r_q [3];
	logic [16:0]        w_q, u_q;
	logic [20:0]        den_q;
	logic [36:0]        num_q;

	// Shared divider.
	logic [DIV_W-1:0] div_dvd_q, div_quo_q;
	logic [DSR_W-1:0] div_dsr_q, div_rem_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             div_go;
	logic [DIV_W-1:0] div_dvd_in;
	logic [DSR_W-1:0] div_dsr_in;
	logic [DSR_W:0]   div_trial;
	logic             div_ge;

	// Shared multiplier.
	logic [19:0] mul_a, mul_b;
	logic [39:0] prod;

	// Combinational helpers.
	logic signed [10:0] err_in;
	logic signed [11:0] diff_in;
	logic [10:0]        mag_e_in;
	logic signed [17:0] x_sel, p0, p1, p2, p3, slope_dist, span;
	logic [17:0]        angle;
	logic [16:0]        hi, lo;
	logic               in_xfer, out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;

	assign esc_eff = (error_scale_q == '0) ? 10'd1 : error_scale_q;
	assign rsc_eff = (rate_scale_q == '0) ? 10'd1 : rate_scale_q;
	assign per_eff = (period_q == '0) ? 20'd1 : period_q;

	assign err_in   = $signed(error_px);
	assign diff_in  = 12'(err_in) - 12'(prev_q);
	assign mag_e_in = err_in[10] ? 11'(-err_in) : 11'(err_in);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_scale_q <= 10'd640;
			rate_scale_q  <= 10'd100;
			period_q      <= 20'd33333;
			out_gain_q    <= 9'd180;
			out_min_q     <= 9'd80;
			out_max_q     <= 9'd150;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ERROR_SCALE: error_scale_q <= cfg_data[9:0];
				REG_RATE_SCALE:  rate_scale_q  <= cfg_data[9:0];
				REG_PERIOD:      period_q      <= cfg_data;
				REG_OUT_GAIN:    out_gain_q    <= cfg_data[8:0];
				REG_OUT_MIN:     out_min_q     <= cfg_data[8:0];
				REG_OUT_MAX:     out_max_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Multiplier operand selection by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DIFFM: begin
				mul_a = 20'(mag_d_q);
				mul_b = US_PER_S;
			end
			ST_NR_GO: begin
				mul_a = per_eff;
				mul_b = 20'(rsc_eff);
			end
			ST_RW: begin
				mul_a = 20'(mu_e_q[ri_q]);
				mul_b = 20'(mu_r_q[rj_q]);
			end
			ST_RN: begin
				mul_a = 20'(w_q);
				mul_b = 20'(singleton(3'(3'd6 - ri_q - {1'b0, rj_q})));
			end
			ST_ANG: begin
				mul_a = 20'(u_q);
				mul_b = 20'(out_gain_q);
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// Trapezoid breakpoints of the set under classification.
	assign x_sel = (k_q < 3'd5) ? 18'(ne_q) : 18'(nr_q);
	assign p0 = trap_point(k_q, 2'd0);
	assign p1 = trap_point(k_q, 2'd1);
	assign p2 = trap_point(k_q, 2'd2);
	assign p3 = trap_point(k_q, 2'd3);

	// Slope distance and span for a membership division.
	always_comb begin
		if (x_sel < p1) begin
			slope_dist = x_sel - p0;
			span       = p1 - p0;
		end else begin
			slope_dist = p3 - x_sel;
			span       = p3 - p2;
		end
	end

	// Divider launch: quotients are rounded half up by adding half the divisor to the dividend.
	always_comb begin
		div_go     = 1'b0;
		div_dvd_in = '0;
		div_dsr_in = '0;
		case (state_q)
			ST_IDLE: begin
				div_go     = in_xfer;
				div_dvd_in = DIV_W'({mag_e_in, 14'b0}) + DIV_W'(esc_eff >> 1);
				div_dsr_in = DSR_W'(esc_eff);
			end
			ST_NR_GO: begin
				div_go     = 1'b1;
				div_dvd_in = DIV_W'({tmp_q, 14'b0}) + DIV_W'(prod[29:0] >> 1);
				div_dsr_in = prod[29:0];
			end
			ST_MU: begin
				div_go     = (x_sel >= p0) && (x_sel < p3) && !((x_sel >= p1) && (x_sel < p2));
				div_dvd_in = DIV_W'({slope_dist[15:0], 16'b0}) + DIV_W'(span[15:1]);
				div_dsr_in = DSR_W'(span[15:0]);
			end
			ST_U_GO: begin
				div_go     = (den_q != '0);
				div_dvd_in = DIV_W'(num_q) + DIV_W'(den_q >> 1);
				div_dsr_in = DSR_W'(den_q);
			end
			default: ;
		endcase
	end

	// One restoring division step per cycle.
	assign div_trial = {div_rem_q, div_dvd_q[DIV_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_go) begin
			div_cnt_q <= CNT_W'(DIV_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_dvd_q <= div_dvd_in;
			div_dsr_q <= div_dsr_in;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_dvd_q <= {div_dvd_q[DIV_W-2:0], 1'b0};
			div_rem_q <= div_ge ? DSR_W'(div_trial - {1'b0, div_dsr_q}) : DSR_W'(div_trial);
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
		end
	end

	// Clamp a rounded magnitude to one in Q2.14 and restore its sign.
	function automatic logic signed [15:0] clamp_norm(input logic [DIV_W-1:0] q,
			input logic neg);
		logic [15:0] m;
		m = (q > DIV_W'(NORM_ONE)) ? 16'(NORM_ONE) : q[15:0];
		return neg ? $signed(-m) : $signed(m);
	endfunction

	// Angle rounding and output limits.
	assign angle = 18'((prod[25:0] + 26'd128) >> 8);
	assign hi    = {out_max_q, 8'b0};
	assign lo    = {out_min_q, 8'b0};
	assign out_load = (state_q == ST_ANG) && (!out_valid || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			k_q     <= '0;
			ri_q    <= '0;
			rj_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						prev_q  <= err_in;
						state_q <= ST_DIV_NE;
					end
				end
				ST_DIV_NE: if (div_cnt_q == '0) state_q <= ST_DIFFM;
				ST_DIFFM:  state_q <= ST_NR_GO;
				ST_NR_GO:  state_q <= ST_DIV_NR;
				ST_DIV_NR: begin
					if (div_cnt_q == '0) begin
						k_q     <= '0;
						state_q <= ST_MU;
					end
				end
				ST_MU: begin
					if (div_go) begin
						state_q <= ST_MU_DIV;
					end else if (k_q == 3'd7) begin
						ri_q    <= '0;
						rj_q    <= '0;
						state_q <= ST_RW;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_MU_DIV: begin
					if (div_cnt_q == '0) begin
						if (k_q == 3'd7) begin
							ri_q    <= '0;
							rj_q    <= '0;
							state_q <= ST_RW;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_MU;
						end
					end
				end
				ST_RW: state_q <= ST_RN;
				ST_RN: begin
					if (rj_q == 2'd2) begin
						rj_q <= '0;
						if (ri_q == 3'd4) begin
							state_q <= ST_U_GO;
						end else begin
							ri_q    <= ri_q + 1'b1;
							state_q <= ST_RW;
						end
					end else begin
						rj_q    <= rj_q + 1'b1;
						state_q <= ST_RW;
					end
				end
				ST_U_GO:  state_q <= div_go ? ST_DIV_U : ST_ANG;
				ST_DIV_U: if (div_cnt_q == '0) state_q <= ST_ANG;
				ST_ANG:   if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					sign_e_q <= err_in[10];
					sign_d_q <= diff_in[11];
					mag_d_q  <= diff_in[11] ? 12'(-diff_in) : 12'(diff_in);
				end
			end
			ST_DIV_NE: if (div_cnt_q == '0) ne_q <= clamp_norm(div_quo_q, sign_e_q);
			ST_DIFFM:  tmp_q <= prod[30:0];
			ST_DIV_NR: if (div_cnt_q == '0) nr_q <= clamp_norm(div_quo_q, sign_d_q);
			ST_MU: begin
				if (!div_go) begin
					if (k_q < 3'd5) begin
						mu_e_q[k_q] <= (x_sel >= p1 && x_sel < p2) ? MU_ONE : '0;
					end else begin
						mu_r_q[2'(k_q - 3'd5)] <= (x_sel >= p1 && x_sel < p2) ? MU_ONE : '0;
					end
				end
				num_q <= '0;
				den_q <= '0;
			end
			ST_MU_DIV: begin
				if (div_cnt_q == '0) begin
					if (k_q < 3'd5) begin
						mu_e_q[k_q] <= div_quo_q[16:0];
					end else begin
						mu_r_q[2'(k_q - 3'd5)] <= div_quo_q[16:0];
					end
				end
				num_q <= '0;
				den_q <= '0;
			end
			ST_RW: begin
				w_q   <= prod[32:16];
				den_q <= den_q + 21'(prod[32:16]);
			end
			ST_RN:    num_q <= num_q + 37'(prod[32:0]);
			ST_U_GO:  u_q <= '0;
			ST_DIV_U: if (div_cnt_q == '0) u_q <= div_quo_q[16:0];
			default: ;
		endcase
	end

	// Output register: a result waits here until it is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (angle > 18'(hi)) begin
				drive_angle <= hi;
				clipped     <= 1'b1;
			end else if (angle < 18'(lo)) begin
				drive_angle <= lo;
				clipped     <= 1'b1;
			end else begin
				drive_angle <= angle[16:0];
				clipped     <= 1'b0;
			end
		end
	end

	// Checks on the sequencer and the shared divider.
	`AST_ALWAYS(a_idle_div_free, in_ready |-> (div_cnt_q == '0))
	`AST_NEXT(a_accept_busy, in_xfer, !in_ready && (div_cnt_q == CNT_W'(DIV_W)))
	`AST_ALWAYS(a_rule_index, (state_q == ST_RW || state_q == ST_RN) |-> (ri_q < 3'd5 && rj_q < 2'd3))
	`AST_NEXT(a_load_valid, out_load, out_valid && in_ready)

endmodule

`default_nettype wire
